// File: hw/rtl/sfge_pkg.sv
// Shared types, constants and helper functions of the scaled font glyph expander.
// No dependencies; every other file of the block imports this package.
package sfge_pkg;

   localparam int BitsPerByte = 8;
   localparam int QueueDepth  = 2;

   localparam logic [1:0] CsrFgColor   = 2'd0;
   localparam logic [1:0] CsrBgColor   = 2'd1;
   localparam logic [1:0] CsrScale     = 2'd2;
   localparam logic [1:0] CsrGlyphRows = 2'd3;

   localparam logic [3:0] ScaleMax = 4'd8;
   localparam logic [5:0] RowsMax  = 6'd32;

   // one classified glyph byte, ready for expansion into eight squares
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] ybase;
      logic [7:0]  bits;
      logic [3:0]  scale;
      logic        last;
   } entry_type;

   // queue status seen by the back end, and its pop request
   typedef struct packed {
      logic valid;
   } queue_stat_type;

   typedef struct packed {
      logic pop;
   } queue_ctrl_type;

   function automatic logic [3:0] eff_scale(input logic [3:0] raw);
      logic [3:0] res;
      if (raw == 4'd0) begin
         res = 4'd1;
      end else if (raw > ScaleMax) begin
         res = ScaleMax;
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic [5:0] eff_rows(input logic [5:0] raw);
      logic [5:0] res;
      if (raw == 6'd0) begin
         res = 6'd1;
      end else if (raw > RowsMax) begin
         res = RowsMax;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/sfge_front.sv
// Front end: accepts glyph byte beats, tracks column and byte-row position,
// computes the square origin and inversion, and pushes one entry per byte. Uses sfge_pkg.
module sfge_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_ready,
   input  logic [7:0]          glyph_byte,
   input  logic                first_of_glyph,
   input  logic [7:0]          glyph_width,
   input  logic [15:0]         origin_x,
   input  logic [15:0]         origin_y,
   input  logic [15:0]         fg_color,
   input  logic [3:0]          scale,
   input  logic [5:0]          rows,
   output logic                push,
   output sfge_pkg::entry_type push_entry
);
   import sfge_pkg::*;

   logic [7:0]  col_ff, col_in;
   logic [4:0]  row_ff, row_in;
   logic [7:0]  width_ff, width_in;
   logic [15:0] ox_ff, ox_in;
   logic [15:0] oy_ff, oy_in;

   logic [7:0]  cur_width;
   logic [7:0]  cur_col;
   logic [4:0]  cur_row;
   logic [15:0] cur_ox;
   logic [15:0] cur_oy;
   logic        col_end;
   logic        row_end;
   logic [11:0] prod_x;
   logic [8:0]  prod_y;

   always_comb begin
      push = in_valid && in_ready;

      if (first_of_glyph) begin
         cur_width = (glyph_width == 8'd0) ? 8'd1 : glyph_width;
         cur_col   = 8'd0;
         cur_row   = 5'd0;
         cur_ox    = origin_x;
         cur_oy    = origin_y;
      end else begin
         cur_width = width_ff;
         cur_col   = col_ff;
         cur_row   = row_ff;
         cur_ox    = ox_ff;
         cur_oy    = oy_ff;
      end

      col_end = ({1'b0, cur_col} + 9'd1) >= {1'b0, cur_width};
      row_end = ({1'b0, cur_row} + 6'd1) >= rows;

      prod_x = {8'd0, scale} * {4'd0, cur_col};
      prod_y = {5'd0, scale} * {4'd0, cur_row};

      push_entry.x     = cur_ox + {4'd0, prod_x};
      push_entry.ybase = cur_oy + {4'd0, prod_y, 3'd0};
      push_entry.bits  = (fg_color == 16'd0) ? ~glyph_byte : glyph_byte;
      push_entry.scale = scale;
      push_entry.last  = col_end && row_end;

      width_in = width_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (push) begin
         width_in = cur_width;
         ox_in    = cur_ox;
         oy_in    = cur_oy;
         if (col_end) begin
            col_in = 8'd0;
            row_in = row_end ? 5'd0 : cur_row + 5'd1;
         end else begin
            col_in = cur_col + 8'd1;
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 8'd0;
         row_ff   <= 5'd0;
         width_ff <= 8'd1;
         ox_ff    <= 16'd0;
         oy_ff    <= 16'd0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         width_ff <= width_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
      end
   end

endmodule

// File: hw/rtl/sfge_queue.sv
// Two-entry queue between front and back end of the glyph expander.
// Uses sfge_pkg for the entry type and depth.
module sfge_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sfge_pkg::entry_type     push_entry,
   output logic                    full,
   input  sfge_pkg::queue_ctrl_type ctrl,
   output sfge_pkg::queue_stat_type stat,
   output sfge_pkg::entry_type     head
);
   import sfge_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   entry_type       slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_pop;

   always_comb begin
      full       = (cnt_ff == CntW'(QueueDepth));
      stat.valid = (cnt_ff != '0);
      head       = slot_ff[rd_ff];
      do_pop     = ctrl.pop && stat.valid;

      wr_in  = push   ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/sfge_back.sv
// Back end: expands each queued entry into eight squares, one per cycle unless the
// output stalls, into a registered output stage. Uses sfge_pkg.
module sfge_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sfge_pkg::queue_stat_type stat,
   input  sfge_pkg::entry_type      head,
   output sfge_pkg::queue_ctrl_type ctrl,
   input  logic [15:0]              fg_color,
   input  logic [15:0]              bg_color,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [15:0]              pixel_x,
   output logic [15:0]              pixel_y,
   output logic [3:0]               square_size,
   output logic [15:0]              pixel_color,
   output logic                     last_of_glyph
);
   import sfge_pkg::*;

   localparam logic [2:0] LastBit = 3'(BitsPerByte - 1);

   logic        busy_ff, busy_in;
   logic [2:0]  k_ff, k_in;
   logic [15:0] y_ff, y_in;
   entry_type   cur_ff, cur_in;

   logic        ovalid_ff, ovalid_in;
   logic [15:0] ox_ff, ox_in;
   logic [15:0] oy_ff, oy_in;
   logic [3:0]  osize_ff, osize_in;
   logic [15:0] ocolor_ff, ocolor_in;
   logic        olast_ff, olast_in;

   logic        emit;
   logic        load;

   always_comb begin
      emit     = busy_ff && (!ovalid_ff || out_ready);
      load     = stat.valid && (!busy_ff || (emit && k_ff == LastBit));
      ctrl.pop = load;

      ovalid_in = emit ? 1'b1 : (ovalid_ff && !out_ready);
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      osize_in  = osize_ff;
      ocolor_in = ocolor_ff;
      olast_in  = olast_ff;
      if (emit) begin
         ox_in     = cur_ff.x;
         oy_in     = y_ff;
         osize_in  = cur_ff.scale;
         ocolor_in = cur_ff.bits[k_ff] ? fg_color : bg_color;
         olast_in  = cur_ff.last && (k_ff == LastBit);
      end

      busy_in = busy_ff;
      k_in    = k_ff;
      y_in    = y_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         k_in    = 3'd0;
         y_in    = head.ybase;
         cur_in  = head;
      end else if (emit) begin
         // advance to the next bit; drop out of busy after the eighth square
         k_in    = k_ff + 3'd1;
         y_in    = y_ff + {12'd0, cur_ff.scale};
         busy_in = (k_ff != LastBit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         k_ff      <= 3'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         k_ff      <= k_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      cur_ff    <= cur_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      osize_ff  <= osize_in;
      ocolor_ff <= ocolor_in;
      olast_ff  <= olast_in;
   end

   assign out_valid     = ovalid_ff;
   assign pixel_x       = ox_ff;
   assign pixel_y       = oy_ff;
   assign square_size   = osize_ff;
   assign pixel_color   = ocolor_ff;
   assign last_of_glyph = olast_ff;

   a_emit_needs_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> busy_ff)
      else $error("square emitted with no entry loaded");

   a_mid_byte_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (emit && k_ff != LastBit) |=> (busy_ff && k_ff == $past(k_ff) + 3'd1))
      else $error("byte expansion cut short");

   a_load_restarts_bit: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && k_ff == 3'd0))
      else $error("new entry did not start at bit zero");

   a_last_on_final_bit: assert property (@(posedge clock) disable iff (reset)
      (emit && k_ff != LastBit) |=> !olast_ff)
      else $error("glyph end marked before the eighth square");

endmodule

// File: hw/rtl/scaled_font_glyph_expander_unit.sv
// Top level of the scaled font glyph expander: config registers, front end,
// queue and back end. Uses sfge_pkg, sfge_front, sfge_queue and sfge_back.
//
// Each accepted glyph byte beat yields eight square beats, one per cycle from the
// back end's output stage while the result side does not stall; the back end can
// load the next byte as it emits the last square of a byte. The first square of a
// byte passes the queue, the entry register and the output register before it appears.
// A two-entry queue lets the front end keep taking bytes while the back end is still
// expanding or the result side is stalled. Configuration is sampled as items are
// classified and expanded, so write it only while the block is idle.
module scaled_font_glyph_expander_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // glyph_byte, glyph_width, origin_x, origin_y
   input  logic        req_tuser,   // first_of_glyph
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pixel_x, pixel_y, square_size, pixel_color, zero fill
   output logic        rsp_tlast,   // last_of_glyph
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import sfge_pkg::*;

   logic [15:0] fg_ff, fg_in;
   logic [15:0] bg_ff, bg_in;
   logic [3:0]  scale_ff, scale_in;
   logic [5:0]  rows_ff, rows_in;

   logic           q_full;
   logic           push;
   entry_type      push_entry;
   entry_type      head;
   queue_stat_type q_stat;
   queue_ctrl_type q_ctrl;

   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [3:0]  square_size;
   logic [15:0] pixel_color;

   always_comb begin
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      scale_in = scale_ff;
      rows_in  = rows_ff;
      if (csr_we) begin
         case (csr_index)
            CsrFgColor:   fg_in    = csr_wdata;
            CsrBgColor:   bg_in    = csr_wdata;
            CsrScale:     scale_in = csr_wdata[3:0];
            CsrGlyphRows: rows_in  = csr_wdata[5:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff    <= 16'hFFFF;
         bg_ff    <= 16'd0;
         scale_ff <= 4'd1;
         rows_ff  <= 6'd1;
      end else begin
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         scale_ff <= scale_in;
         rows_ff  <= rows_in;
      end
   end

   assign req_tready = !q_full;

   sfge_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .glyph_byte     (req_tdata[7:0]),
      .first_of_glyph (req_tuser),
      .glyph_width    (req_tdata[15:8]),
      .origin_x       (req_tdata[31:16]),
      .origin_y       (req_tdata[47:32]),
      .fg_color       (fg_ff),
      .scale          (eff_scale(scale_ff)),
      .rows           (eff_rows(rows_ff)),
      .push           (push),
      .push_entry     (push_entry)
   );

   sfge_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .ctrl       (q_ctrl),
      .stat       (q_stat),
      .head       (head)
   );

   sfge_back u_back (
      .clock         (clock),
      .reset         (reset),
      .stat          (q_stat),
      .head          (head),
      .ctrl          (q_ctrl),
      .fg_color      (fg_ff),
      .bg_color      (bg_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .pixel_x       (pixel_x),
      .pixel_y       (pixel_y),
      .square_size   (square_size),
      .pixel_color   (pixel_color),
      .last_of_glyph (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, pixel_color, square_size, pixel_y, pixel_x};

endmodule

// File: dv/sfge_checker.sv
`timescale 1ns / 1ps
// Checker for the scaled font glyph expander: watches the config port and both streams,
// predicts the eight squares of every glyph byte and compares them in order.
// Depends on sfge_pkg for the register indexes and the scale and row limits.
module sfge_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // glyph_byte, glyph_width, origin_x, origin_y
   input  logic        req_tuser,   // first_of_glyph
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // pixel_x, pixel_y, square_size, pixel_color, zero fill
   input  logic        rsp_tlast,   // last_of_glyph
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          pending
);
   import sfge_pkg::*;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [3:0]  size;
      logic [15:0] color;
      logic        last;
   } square_type;

   square_type  expected_squares[$];
   int          fail_count = 0;

   logic [15:0] fg_color;
   logic [15:0] bg_color;
   logic [3:0]  scale_raw;
   logic [5:0]  rows_raw;

   logic [7:0]  column_count;
   logic [4:0]  row_count;
   logic [7:0]  held_width;
   logic [15:0] held_x;
   logic [15:0] held_y;

   function automatic int field_mismatch(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // expand one glyph byte into its eight squares and advance the glyph counters
   task automatic expand_byte(input logic [47:0] beat, input logic first);
      logic [7:0]  pixels;
      logic [3:0]  size;
      logic [5:0]  height;
      logic        col_end;
      logic        row_end;
      logic [15:0] left;
      square_type  sq;
      size   = (scale_raw == 4'd0) ? 4'd1 : ((scale_raw > ScaleMax) ? ScaleMax : scale_raw);
      height = (rows_raw == 6'd0) ? 6'd1 : ((rows_raw > RowsMax) ? RowsMax : rows_raw);
      if (first) begin
         held_width   = (beat[15:8] == 8'd0) ? 8'd1 : beat[15:8];
         held_x       = beat[31:16];
         held_y       = beat[47:32];
         column_count = '0;
         row_count    = '0;
      end
      // a black foreground draws the glyph inverted
      pixels  = (fg_color == 16'd0) ? ~beat[7:0] : beat[7:0];
      col_end = ({1'b0, column_count} + 9'd1) >= {1'b0, held_width};
      row_end = ({1'b0, row_count} + 6'd1) >= height;
      left    = held_x + size * column_count;
      for (int k = 0; k < BitsPerByte; k++) begin
         sq.x     = left;
         sq.y     = 16'(held_y + size * (row_count * BitsPerByte + k));
         sq.size  = size;
         sq.color = pixels[k] ? fg_color : bg_color;
         sq.last  = col_end && row_end && (k == BitsPerByte - 1);
         expected_squares.push_back(sq);
      end
      if (col_end) begin
         column_count = '0;
         row_count    = row_end ? 5'd0 : row_count + 5'd1;
      end else begin
         column_count = column_count + 8'd1;
      end
   endtask

   always @(posedge clock) begin
      square_type want;
      if (reset) begin
         fg_color     = 16'hFFFF;
         bg_color     = 16'h0000;
         scale_raw    = 4'd1;
         rows_raw     = 6'd1;
         column_count = '0;
         row_count    = '0;
         held_width   = 8'd1;
         held_x       = '0;
         held_y       = '0;
         expected_squares.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrFgColor:   fg_color  = csr_wdata;
               CsrBgColor:   bg_color  = csr_wdata;
               CsrScale:     scale_raw = csr_wdata[3:0];
               CsrGlyphRows: rows_raw  = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expand_byte(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_squares.size() == 0) begin
               $display("%0t: square beat expected none, got 0x%0h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_squares.pop_front();
               fail_count += field_mismatch("pixel_x", want.x, rsp_tdata[15:0]);
               fail_count += field_mismatch("pixel_y", want.y, rsp_tdata[31:16]);
               fail_count += field_mismatch("square_size", want.size, rsp_tdata[35:32]);
               fail_count += field_mismatch("pixel_color", want.color, rsp_tdata[51:36]);
               fail_count += field_mismatch("last_of_glyph", want.last, rsp_tlast);
               fail_count += field_mismatch("zero fill", 0, rsp_tdata[55:52]);
            end
         end
      end
      // publish after the edge so the stimulus side always reads settled values
      pending  <= expected_squares.size();
      failures <= fail_count;
   end

endmodule

// File: dv/scaled_font_glyph_expander_unit_test.sv
`timescale 1ns / 1ps
// Testbench top of the scaled font glyph expander: clock, reset, glyph byte stimulus,
// register writes and result back-pressure. Depends on sfge_pkg, sfge_checker and the unit.
module scaled_font_glyph_expander_unit_test;
   import sfge_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // glyph_byte, glyph_width, origin_x, origin_y
   logic        req_tuser  = 1'b0; // first_of_glyph
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // pixel_x, pixel_y, square_size, pixel_color, zero fill
   logic        rsp_tlast;         // last_of_glyph
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CsrFgColor;
   logic [15:0] csr_wdata  = '0;

   int          failures;
   int          pending;
   int          bytes_sent      = 0;
   int          sender_idle_pct = 0;
   int          stall_pct       = 0;
   int          hold_request    = 0;
   int          hold_served     = 0;
   int          hold_left       = 0;
   int          cycle_count     = 0;
   logic [5:0]  rows_setting    = 6'd1;

   scaled_font_glyph_expander_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sfge_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_left   <= HoldCycles;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left   <= hold_left - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready  <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] glyph_byte, input logic first,
                            input logic [7:0] width, input logic [15:0] ox,
                            input logic [15:0] oy);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {oy, ox, width, glyph_byte};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_noise_byte(input logic first);
      send_byte(8'($urandom), first, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // first byte carries the header, the rest random content with ignored header fields
   task automatic send_glyph(input logic [7:0] width, input int n_bytes);
      send_byte(8'($urandom), 1'b1, width, 16'($urandom), 16'($urandom));
      for (int i = 1; i < n_bytes; i++) begin
         send_noise_byte(1'b0);
      end
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_settings(input logic [15:0] fg, input logic [15:0] bg,
                                 input logic [3:0] scale, input logic [5:0] rows);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CsrFgColor;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CsrBgColor;
      csr_wdata <= bg;
      @(posedge clock);
      csr_index <= CsrScale;
      csr_wdata <= {12'd0, scale};
      @(posedge clock);
      csr_index <= CsrGlyphRows;
      csr_wdata <= {10'd0, rows};
      @(posedge clock);
      csr_we    <= 1'b0;
      rows_setting = rows;
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall, input int n_bytes);
      int         target;
      int         kind;
      int         height;
      int         glyph_len;
      logic [7:0] width;
      logic [15:0] fg;
      case ($urandom_range(0, 3))
         0:       fg = 16'h0000;
         1:       fg = 16'hFFFF;
         default: fg = 16'($urandom);
      endcase
      write_settings(fg, 16'($urandom), 4'($urandom_range(0, 15)),
                     6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(1, 4)));
      sender_idle_pct = idle_pct;
      stall_pct      <= stall;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         kind   = $urandom_range(0, 9);
         width  = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 3));
         height = (rows_setting == 0) ? 1 : ((rows_setting > 32) ? 32 : rows_setting);
         glyph_len = ((width == 0) ? 1 : width) * height;
         if (glyph_len > 24) glyph_len = 24;
         if (kind <= 6) begin
            send_glyph(width, glyph_len);
         end else if (kind == 7) begin
            send_glyph(width, $urandom_range(1, glyph_len));
         end else if (kind == 8) begin
            // run past the end of the glyph, or continue a broken one
            repeat ($urandom_range(1, 4)) send_noise_byte(1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) send_noise_byte(1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty and full bytes, zero width, origin at the wrap point
      send_byte(8'h00, 1'b1, 8'd1, 16'h0000, 16'h0000);
      send_byte(8'hFF, 1'b1, 8'd0, 16'hFFFF, 16'hFFFF);
      send_byte(8'hA5, 1'b0, 8'hFF, 16'h1234, 16'h5678);

      // inverted glyph, scale clamped to the top, zero rows used as one
      write_settings(16'h0000, 16'h1234, 4'd15, 6'd0);
      send_byte(8'h5A, 1'b1, 8'd2, 16'hFFF0, 16'hFFF8);
      send_byte(8'h01, 1'b0, 8'd0, 16'h0000, 16'h0000);
      send_byte(8'h80, 1'b0, 8'd7, 16'hAAAA, 16'h5555);

      // widest glyph at full scale, rows clamped to the maximum; leave it open
      write_settings(16'hF800, 16'h07E0, 4'd8, 6'd63);
      send_byte(8'hFF, 1'b1, 8'd255, 16'h8000, 16'h0000);
      send_byte(8'h00, 1'b0, 8'd0, 16'h7FFF, 16'hFFFF);

      // lower the height below the current byte-row: that row ends the glyph
      write_settings(16'h001F, 16'hFFFF, 4'd0, 6'd4);
      send_byte(8'h3C, 1'b1, 8'd1, 16'h0100, 16'hFFE0);
      send_byte(8'hC3, 1'b0, 8'd1, 16'h0000, 16'h0000);
      send_byte(8'h0F, 1'b0, 8'd1, 16'h0000, 16'h0000);
      write_settings(16'h001F, 16'hFFFF, 4'd0, 6'd2);
      send_byte(8'hF0, 1'b0, 8'd1, 16'h0000, 16'h0000);
      send_byte(8'h11, 1'b0, 8'd1, 16'h0000, 16'h0000);

      write_settings(16'hFFFF, 16'h0000, 4'd1, 6'd32);
      send_glyph(8'd1, 4);
      write_settings(16'h7BEF, 16'h8410, 4'd3, 6'd3);
      send_glyph(8'd2, 6);

      // long hold-off on the result side while bytes keep coming
      wait_drained();
      hold_request <= hold_request + 1;
      send_glyph(8'd3, 12);

      run_random_phase(0, 0, 50);
      run_random_phase(63, 0, 50);
      run_random_phase(0, 63, 50);
      run_random_phase(24, 24, 50);

      wait_drained();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: scaled_font_glyph_expander_unit.f
hw/rtl/sfge_pkg.sv
hw/rtl/sfge_front.sv
hw/rtl/sfge_queue.sv
hw/rtl/sfge_back.sv
hw/rtl/scaled_font_glyph_expander_unit.sv
dv/sfge_checker.sv
dv/scaled_font_glyph_expander_unit_test.sv
